>>> hdl/pnpr_pkg.sv
// Shared types, constants and register codes of the planar pixel normalizer.
package pnpr_pkg;

    localparam int PIX_BITS       = 8;
    localparam int SCALE_BITS     = 18;
    localparam int OFFSET_BITS    = 16;
    localparam int DIM_BITS       = 11;
    localparam int IDX_BITS       = 22;
    localparam int PLANE_BITS     = 2;
    localparam int NORM_BITS      = 16;
    localparam int PROD_BITS      = PIX_BITS + SCALE_BITS;
    localparam int NORM_SHIFT     = 5;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 18;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [DIM_BITS-1:0]    RST_DIM    = DIM_BITS'(1024);
    localparam logic [SCALE_BITS-1:0]  RST_SCALE  = SCALE_BITS'(256);
    localparam logic [OFFSET_BITS-1:0] RST_OFFSET = '0;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_SCALE_RED    = 3'd2,
        REG_SCALE_GREEN  = 3'd3,
        REG_SCALE_BLUE   = 3'd4,
        REG_OFFSET_RED   = 3'd5,
        REG_OFFSET_GREEN = 3'd6,
        REG_OFFSET_BLUE  = 3'd7
    } cfg_reg_e;

    typedef enum logic [PLANE_BITS-1:0] {
        PLANE_RED   = 2'd0,
        PLANE_GREEN = 2'd1,
        PLANE_BLUE  = 2'd2
    } plane_e;

    typedef struct packed {
        logic [PIX_BITS-1:0] blue_byte;
        logic [PIX_BITS-1:0] green_byte;
        logic [PIX_BITS-1:0] red_byte;
    } pixel_t;

    typedef struct packed {
        logic [PLANE_BITS-1:0]       plane;
        logic [IDX_BITS-1:0]         dest_index;
        logic signed [NORM_BITS-1:0] norm_value;
        logic                        run_last;
        logic                        image_last;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_BITS-1:0]  index;
        logic [CFG_DATA_BITS-1:0] value;
    } cfg_word_t;

    typedef struct packed {
        logic [SCALE_BITS-1:0]         scale_red;
        logic [SCALE_BITS-1:0]         scale_green;
        logic [SCALE_BITS-1:0]         scale_blue;
        logic signed [OFFSET_BITS-1:0] offset_red;
        logic signed [OFFSET_BITS-1:0] offset_green;
        logic signed [OFFSET_BITS-1:0] offset_blue;
    } gains_t;

    // Products and index terms of one pixel, handed from compute to serializer.
    typedef struct packed {
        logic [PROD_BITS-1:0] prod_red;
        logic [PROD_BITS-1:0] prod_green;
        logic [PROD_BITS-1:0] prod_blue;
        logic [IDX_BITS-1:0]  pos;
        logic [IDX_BITS-1:0]  plane_size;
        logic                 image_last;
    } pixel_terms_t;

endpackage

>>> hdl/pnpr_stream_if.sv
// Valid/ready channel carrying one word of a given payload type.
interface pnpr_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/pnpr_cfg_regs.sv
// Configuration registers with clamped image geometry.
module pnpr_cfg_regs #(
    parameter int MAX_WIDTH  = pnpr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = pnpr_pkg::DEF_MAX_HEIGHT,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    pnpr_stream_if.sink          cfg,
    output logic [WW-1:0]        eff_width,
    output logic [HW-1:0]        eff_height,
    output pnpr_pkg::gains_t     gains
);
    import pnpr_pkg::*;

    logic [DIM_BITS-1:0] width_reg;
    logic [DIM_BITS-1:0] height_reg;
    gains_t              gains_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg              <= RST_DIM;
            height_reg             <= RST_DIM;
            gains_reg.scale_red    <= RST_SCALE;
            gains_reg.scale_green  <= RST_SCALE;
            gains_reg.scale_blue   <= RST_SCALE;
            gains_reg.offset_red   <= RST_OFFSET;
            gains_reg.offset_green <= RST_OFFSET;
            gains_reg.offset_blue  <= RST_OFFSET;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_e'(cfg.data.index))
                REG_IMAGE_WIDTH:  width_reg  <= cfg.data.value[DIM_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg.data.value[DIM_BITS-1:0];
                REG_SCALE_RED:    gains_reg.scale_red   <= cfg.data.value[SCALE_BITS-1:0];
                REG_SCALE_GREEN:  gains_reg.scale_green <= cfg.data.value[SCALE_BITS-1:0];
                REG_SCALE_BLUE:   gains_reg.scale_blue  <= cfg.data.value[SCALE_BITS-1:0];
                REG_OFFSET_RED:   gains_reg.offset_red   <= cfg.data.value[OFFSET_BITS-1:0];
                REG_OFFSET_GREEN: gains_reg.offset_green <= cfg.data.value[OFFSET_BITS-1:0];
                REG_OFFSET_BLUE:  gains_reg.offset_blue  <= cfg.data.value[OFFSET_BITS-1:0];
                default: ;
            endcase
        end
    end

    // A zero size counts as one; sizes above the maximum are held at it.
    always_comb
    begin
        if (width_reg == '0)
            eff_width = WW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            eff_width = WW'(MAX_WIDTH);
        else
            eff_width = WW'(width_reg);

        if (height_reg == '0)
            eff_height = HW'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            eff_height = HW'(MAX_HEIGHT);
        else
            eff_height = HW'(height_reg);
    end

    assign gains = gains_reg;

endmodule

>>> hdl/pnpr_position.sv
// Raster position counters that place each accepted pixel.
module pnpr_position #(
    parameter int MAX_WIDTH  = pnpr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = pnpr_pkg::DEF_MAX_HEIGHT,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [WW-1:0] eff_width,
    input  logic [HW-1:0] eff_height,
    output logic [CW-1:0] col,
    output logic [RW-1:0] row,
    output logic          image_last
);
    import pnpr_pkg::*;

    localparam int XW = WW + 1;
    localparam int YW = HW + 1;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [XW-1:0] col_here;
    logic [YW-1:0] row_here;
    logic [XW-1:0] col_next;
    logic [YW-1:0] row_next;

    always_comb
    begin
        col_here = XW'(col_reg);
        row_here = YW'(row_reg);
        // A counter left beyond a shrunken geometry wraps before placing.
        if (col_here >= XW'(eff_width))
        begin
            col_here = '0;
            row_here = row_here + YW'(1);
        end
        if (row_here >= YW'(eff_height))
            row_here = '0;

        col_next = col_here + XW'(1);
        row_next = row_here;
        if (col_next >= XW'(eff_width))
        begin
            col_next = '0;
            row_next = row_here + YW'(1);
            if (row_next >= YW'(eff_height))
                row_next = '0;
        end
    end

    assign col        = col_here[CW-1:0];
    assign row        = row_here[RW-1:0];
    assign image_last = (row_here == YW'(eff_height) - YW'(1)) &&
                        (col_here == XW'(eff_width) - XW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next[CW-1:0];
            row_reg <= row_next[RW-1:0];
        end
    end

    // The final pixel of an image always brings both counters back to the origin.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && image_last |=> col_reg == '0 && row_reg == '0)
        else $error("counters did not wrap after the final pixel");

endmodule

>>> hdl/pnpr_compute.sv
// Input register and product stage: channel products and planar index terms.
module pnpr_compute #(
    parameter int MAX_WIDTH  = pnpr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = pnpr_pkg::DEF_MAX_HEIGHT,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    pnpr_stream_if.sink             pix,
    input  logic [CW-1:0]           col,
    input  logic [RW-1:0]           row,
    input  logic                    image_last,
    input  logic [WW-1:0]           eff_width,
    input  logic [HW-1:0]           eff_height,
    input  pnpr_pkg::gains_t        gains,
    output logic                    terms_valid,
    input  logic                    terms_ready,
    output pnpr_pkg::pixel_terms_t  terms
);
    import pnpr_pkg::*;

    localparam int PW0 = RW + WW + 1;
    localparam int PW1 = HW + WW;
    localparam int PWA = (PW0 > IDX_BITS) ? PW0 : IDX_BITS;
    localparam int PWB = (PW1 > IDX_BITS) ? PW1 : IDX_BITS;

    logic          a_valid_reg;
    pixel_t        a_pix_reg;
    logic [CW-1:0] a_col_reg;
    logic [RW-1:0] a_row_reg;
    logic          a_last_reg;
    logic          a_ready;

    logic          b_valid_reg;
    pixel_terms_t  b_terms_reg;
    pixel_terms_t  b_terms_next;
    logic          b_ready;

    logic [PWA-1:0] pos_full;
    logic [PWB-1:0] size_full;

    assign b_ready   = !b_valid_reg || terms_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign pix.ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= pix.valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && pix.valid)
        begin
            a_pix_reg  <= pix.data;
            a_col_reg  <= col;
            a_row_reg  <= row;
            a_last_reg <= image_last;
        end
        if (b_ready && a_valid_reg)
            b_terms_reg <= b_terms_next;
    end

    always_comb
    begin
        pos_full  = PWA'(a_row_reg) * PWA'(eff_width) + PWA'(a_col_reg);
        size_full = PWB'(eff_height) * PWB'(eff_width);

        b_terms_next.prod_red   = PROD_BITS'(a_pix_reg.red_byte) *
                                  PROD_BITS'(gains.scale_red);
        b_terms_next.prod_green = PROD_BITS'(a_pix_reg.green_byte) *
                                  PROD_BITS'(gains.scale_green);
        b_terms_next.prod_blue  = PROD_BITS'(a_pix_reg.blue_byte) *
                                  PROD_BITS'(gains.scale_blue);
        b_terms_next.pos        = pos_full[IDX_BITS-1:0];
        b_terms_next.plane_size = size_full[IDX_BITS-1:0];
        b_terms_next.image_last = a_last_reg;
    end

    assign terms_valid = b_valid_reg;
    assign terms       = b_terms_reg;

    // A word held in the product stage may only leave through the serializer.
    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !terms_ready |=> b_valid_reg)
        else $error("product stage dropped a word under stall");

endmodule

>>> hdl/pnpr_serializer.sv
// Output stage: saturates the three channels and emits them in plane order.
module pnpr_serializer (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    terms_valid,
    output logic                    terms_ready,
    input  pnpr_pkg::pixel_terms_t  terms,
    input  pnpr_pkg::gains_t        gains,
    pnpr_stream_if.source           res
);
    import pnpr_pkg::*;

    localparam int SUM_BITS = PROD_BITS - NORM_SHIFT + 2;

    logic                        c_valid_reg;
    logic                        c_valid_next;
    plane_e                      c_plane_reg;
    plane_e                      c_plane_next;
    logic                        c_last_reg;
    logic signed [NORM_BITS-1:0] c_norm_reg [3];
    logic [IDX_BITS-1:0]         c_dest_reg [3];
    logic                        out_take;
    logic                        load;

    function automatic logic signed [NORM_BITS-1:0] sat_norm(
        input logic [PROD_BITS-1:0]          prod,
        input logic signed [OFFSET_BITS-1:0] offset
    );
        logic signed [SUM_BITS-1:0] sum;
        begin
            sum = $signed({2'b00, prod[PROD_BITS-1:NORM_SHIFT]}) + SUM_BITS'(offset);
            if (sum > SUM_BITS'(32767))
                sat_norm = 16'sh7FFF;
            else if (sum < -SUM_BITS'(32768))
                sat_norm = 16'sh8000;
            else
                sat_norm = sum[NORM_BITS-1:0];
        end
    endfunction

    assign out_take    = c_valid_reg && res.ready;
    assign terms_ready = !c_valid_reg || (res.ready && c_plane_reg == PLANE_BLUE);
    assign load        = terms_valid && terms_ready;

    always_comb
    begin
        c_valid_next = c_valid_reg;
        c_plane_next = c_plane_reg;
        if (load)
        begin
            c_valid_next = 1'b1;
            c_plane_next = PLANE_RED;
        end
        else if (out_take)
        begin
            case (c_plane_reg)
                PLANE_RED:   c_plane_next = PLANE_GREEN;
                PLANE_GREEN: c_plane_next = PLANE_BLUE;
                default:     c_valid_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            c_plane_reg <= PLANE_RED;
        end
        else
        begin
            c_valid_reg <= c_valid_next;
            c_plane_reg <= c_plane_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            c_norm_reg[0] <= sat_norm(terms.prod_red, gains.offset_red);
            c_norm_reg[1] <= sat_norm(terms.prod_green, gains.offset_green);
            c_norm_reg[2] <= sat_norm(terms.prod_blue, gains.offset_blue);
            c_dest_reg[0] <= terms.pos;
            c_dest_reg[1] <= terms.pos + terms.plane_size;
            c_dest_reg[2] <= terms.pos + {terms.plane_size[IDX_BITS-2:0], 1'b0};
            c_last_reg    <= terms.image_last;
        end
    end

    always_comb
    begin
        res.valid           = c_valid_reg;
        res.data.plane      = c_plane_reg;
        res.data.run_last   = (c_plane_reg == PLANE_BLUE);
        res.data.image_last = c_last_reg;
        case (c_plane_reg)
            PLANE_RED:
            begin
                res.data.dest_index = c_dest_reg[0];
                res.data.norm_value = c_norm_reg[0];
            end
            PLANE_GREEN:
            begin
                res.data.dest_index = c_dest_reg[1];
                res.data.norm_value = c_norm_reg[1];
            end
            default:
            begin
                res.data.dest_index = c_dest_reg[2];
                res.data.norm_value = c_norm_reg[2];
            end
        endcase
    end

    // After the blue word is taken, any following word starts a new pixel at red.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_take && c_plane_reg == PLANE_BLUE |=> !c_valid_reg || c_plane_reg == PLANE_RED)
        else $error("pixel did not restart at the red plane");

    // Red and green words are followed by the next plane of the same pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_take && c_plane_reg == PLANE_RED |=> c_valid_reg && c_plane_reg == PLANE_GREEN)
        else $error("green word missing after red");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_take && c_plane_reg == PLANE_GREEN |=> c_valid_reg && c_plane_reg == PLANE_BLUE)
        else $error("blue word missing after green");

endmodule

>>> hdl/pixel_normalize_planar_reorder.sv
// Top level of the planar pixel normalizer.
//
// pix takes one interleaved pixel word (blue, green, red bytes) per handshake,
// in raster order. res gives three words per pixel, red, green and blue, each
// with its plane, planar destination index, saturated Q12.3 value, a flag on
// the blue word and a flag on all words of the image's final pixel.
// cfg writes one register per handshake and is always ready; it is meant to
// be used only while no pixel is in flight.
// A pixel accepted on pix passes the input register and the product stage
// before its red word is registered in the output stage. The output channel
// moves one word per cycle while res is ready and so sets the pixel rate; an
// input register, a product stage and the output stage each hold one pixel.
// Reset clears the raster counters, empties every stage and loads the default
// geometry (1024 by 1024), gains of 256 and zero offsets.
// When res stalls the stages fill in turn; pix.ready drops once all three
// hold a pixel, and no word is lost or repeated.
module pixel_normalize_planar_reorder #(
    parameter int MAX_WIDTH  = pnpr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = pnpr_pkg::DEF_MAX_HEIGHT
) (
    input  logic           clk,
    input  logic           rst_n,
    pnpr_stream_if.sink    pix,
    pnpr_stream_if.source  res,
    pnpr_stream_if.sink    cfg
);
    import pnpr_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [WW-1:0] eff_width;
    logic [HW-1:0] eff_height;
    gains_t        gains;
    logic [CW-1:0] col;
    logic [RW-1:0] row;
    logic          image_last;
    logic          pix_accept;
    logic          terms_valid;
    logic          terms_ready;
    pixel_terms_t  terms;

    assign pix_accept = pix.valid && pix.ready;

    pnpr_cfg_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .gains      (gains)
    );

    pnpr_position #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_position (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (pix_accept),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .col        (col),
        .row        (row),
        .image_last (image_last)
    );

    pnpr_compute #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_compute (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix         (pix),
        .col         (col),
        .row         (row),
        .image_last  (image_last),
        .eff_width   (eff_width),
        .eff_height  (eff_height),
        .gains       (gains),
        .terms_valid (terms_valid),
        .terms_ready (terms_ready),
        .terms       (terms)
    );

    pnpr_serializer u_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .terms_valid (terms_valid),
        .terms_ready (terms_ready),
        .terms       (terms),
        .gains       (gains),
        .res         (res)
    );

endmodule
